// File: rtl/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int HEADER_DIGITS = 10;
    localparam int LEN_W         = 34;
    localparam int DIG_W         = $clog2(HEADER_DIGITS + 1);
    localparam int ACC_W         = LEN_W + 4;

    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [7:0]       CHAR_ZERO = 8'h30;
    localparam logic [7:0]       CHAR_NINE = 8'h39;

    localparam int TUSER_EMPTY = 0;
    localparam int TUSER_BAD   = 1;

endpackage

// File: rtl/length_prefix_deframer.sv
`timescale 1ns / 1ps

// Splits a byte stream into strings, each preceded by a fixed-width ASCII
// decimal length header (HEADER_DIGITS characters, most significant first).
// Header bytes produce no output transaction, except the byte that completes a
// zero-length header, which produces an empty-string marker (tuser empty bit
// and tlast set, data zero). Payload bytes pass through with tlast on the final
// byte of each string. A non-digit header byte produces an error marker (tuser
// bad bit set, data zero) and the header starts over. The block takes one byte
// per clock while m_tready is held high: a byte is held in the input register,
// the header/countdown logic (one multiply-by-ten add and one decrement on the
// 34-bit length) runs between that register and the output register.
module length_prefix_deframer
    import lpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] is_empty, [1] bad_digit
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic [1:0]       out_user_reg, out_user_next;

    logic             in_payload_reg, in_payload_next;
    logic [DIG_W-1:0] digits_seen_reg, digits_seen_next;
    logic [LEN_W-1:0] length_left_reg, length_left_next;

    logic             advance;
    logic             has_result;
    logic             payload_active;
    logic [LEN_W-1:0] len_dec;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] acc;
    logic [LEN_W-1:0] len_acc;
    logic [DIG_W-1:0] dig_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign payload_active = in_payload_reg && (length_left_reg != '0);
    assign len_dec        = length_left_reg - LEN_W'(1);
    assign is_digit       = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign digit          = 4'(in_byte_reg - CHAR_ZERO);
    assign acc            = {1'b0, length_left_reg, 3'b000}
                          + {3'b000, length_left_reg, 1'b0}
                          + {{LEN_W{1'b0}}, digit};
    assign len_acc        = (acc[ACC_W-1:LEN_W] != '0) ? LEN_MAX : acc[LEN_W-1:0];
    assign dig_inc        = digits_seen_reg + DIG_W'(1);

    always_comb begin
        in_payload_next  = in_payload_reg;
        digits_seen_next = digits_seen_reg;
        length_left_next = length_left_reg;
        has_result       = 1'b0;
        out_byte_next    = 8'h00;
        out_last_next    = 1'b0;
        out_user_next    = 2'b00;
        if (payload_active) begin
            length_left_next = len_dec;
            in_payload_next  = (len_dec != '0);
            has_result       = 1'b1;
            out_byte_next    = in_byte_reg;
            out_last_next    = (len_dec == '0);
        end else if (!is_digit) begin
            in_payload_next              = 1'b0;
            digits_seen_next             = '0;
            length_left_next             = '0;
            has_result                   = 1'b1;
            out_user_next[TUSER_BAD]     = 1'b1;
        end else begin
            in_payload_next  = 1'b0;
            length_left_next = len_acc;
            digits_seen_next = dig_inc;
            if (dig_inc >= DIG_W'(HEADER_DIGITS)) begin
                digits_seen_next = '0;
                if (len_acc == '0) begin
                    has_result                 = 1'b1;
                    out_last_next              = 1'b1;
                    out_user_next[TUSER_EMPTY] = 1'b1;
                end else begin
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = has_result;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            in_payload_reg  <= 1'b0;
            digits_seen_reg <= '0;
            length_left_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                in_payload_reg  <= in_payload_next;
                digits_seen_reg <= digits_seen_next;
                length_left_reg <= length_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && has_result) begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_payload_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (length_left_reg != '0))
        else $error("payload phase with nothing due");

    a_digit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digits_seen_reg < DIG_W'(HEADER_DIGITS))
        else $error("digit counter out of range");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_EMPTY]) |-> (m_tlast && m_tdata == 8'h00
            && !m_tuser[TUSER_BAD]))
        else $error("malformed empty marker");

    a_bad_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_BAD]) |-> (!m_tlast && m_tdata == 8'h00))
        else $error("malformed error marker");

    a_payload_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && payload_active) |=> m_tvalid)
        else $error("payload byte dropped");

endmodule
